[src/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// operand and result beats, operation and status codes, sequencer states
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WIDTH = 32;
   localparam int DW    = 2 * WIDTH;
   localparam int KW    = $clog2(DW + 1);
   localparam int CW    = $clog2(DW);

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_DIV = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ZDEN = 2'd1;
   localparam logic [1:0] STAT_OVF  = 2'd2;

   typedef struct packed {
      logic [1:0]              action;
      logic signed [WIDTH-1:0] num_a;
      logic signed [WIDTH-1:0] den_a;
      logic signed [WIDTH-1:0] num_b;
      logic signed [WIDTH-1:0] den_b;
   } req_type;

   typedef struct packed {
      logic signed [WIDTH-1:0] num_out;
      logic signed [WIDTH-1:0] den_out;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic          sub;
      logic [DW:0]   x;
      logic [DW:0]   y;
   } alu_req_type;

   typedef struct packed {
      logic [DW:0] res;
      logic        borrow;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_ADD,
      ST_ADD_SWAP,
      ST_GCD_INIT,
      ST_GCD_TWO,
      ST_GCD_AODD,
      ST_GCD_LOOP,
      ST_GCD_SHL,
      ST_DIV_LOAD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_FINISH
   } state_type;

endpackage

[src/rau_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_mul: registered magnitude multiplier
// one unsigned product per cycle, registered: the result follows in the cycle after the operands
// ----------------------------------------------------------------------------
module rau_mul (
   input  logic                      clock,
   input  logic [rau_pkg::WIDTH-1:0] mul_a,
   input  logic [rau_pkg::WIDTH-1:0] mul_b,
   output logic [rau_pkg::DW-1:0]    prod_ff
);
   import rau_pkg::*;

   logic [DW-1:0] prod_in;

   assign prod_in = DW'(mul_a) * DW'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[src/rau_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_alu: shared wide add / subtract unit
// serves the sign-magnitude add, the gcd steps and the long division
// ----------------------------------------------------------------------------
module rau_alu (
   input  rau_pkg::alu_req_type alu_req,
   output rau_pkg::alu_rsp_type alu_rsp
);
   import rau_pkg::*;

   logic [DW+1:0] sum;

   always_comb begin
      if (alu_req.sub) begin
         sum = {1'b0, alu_req.x} - {1'b0, alu_req.y};
      end else begin
         sum = {1'b0, alu_req.x} + {1'b0, alu_req.y};
      end
      alu_rsp.res    = sum[DW:0];
      alu_rsp.borrow = alu_req.sub & sum[DW+1];
   end

endmodule

[src/rational_arith_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit: exact fraction add, subtract, multiply and divide
// cross products, binary gcd and restoring division on one shared datapath
// ----------------------------------------------------------------------------
// sequence: multiply states MUL0 to MUL3, an add step (plus a swap step when
//   the second term is larger), a gcd setup step, a binary gcd of one shift,
//   swap or subtract per cycle, a division load step, restoring division of
//   the numerator and then the denominator, and a finish step; when one side
//   is zero the gcd loop is skipped; zero over zero skips gcd and division
// throughput: one beat at a time; busy stays high until the result strobe
// the result is held for one cycle on rsp_payload with rsp_strobe; the
//   receiver cannot stall
// reset: synchronous, active high; returns to idle with no strobe pending
module rational_arith_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output rau_pkg::rsp_type rsp_payload
);
   import rau_pkg::*;

   // sequencer
   state_type state_ff, state_in;

   // captured operands as sign and magnitude
   logic [1:0]       act_ff, act_in;
   logic             sna_ff, sda_ff, snb_ff, sdb_ff;
   logic             sna_in, sda_in, snb_in, sdb_in;
   logic [WIDTH-1:0] mna_ff, mda_ff, mnb_ff, mdb_ff;
   logic [WIDTH-1:0] mna_in, mda_in, mnb_in, mdb_in;

   // products
   logic [DW-1:0] p0_ff, p1_ff, p2_ff, p0_in, p1_in, p2_in;
   logic          s0_ff, s1_ff, s2_ff, s0_in, s1_in, s2_in;

   // unreduced and reduced fraction
   logic [DW-1:0] num_m_ff, num_m_in, den_m_ff, den_m_in;
   logic          num_s_ff, num_s_in, den_s_ff, den_s_in;

   // gcd and division state
   logic [DW-1:0] ga_ff, ga_in, gb_ff, gb_in;
   logic [KW-1:0] k_ff, k_in;
   logic [DW-1:0] dn_ff, dn_in, dr_ff, dr_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // result
   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   // multiplier port
   logic [WIDTH-1:0] mul_a, mul_b;
   logic [DW-1:0]    prod;
   logic [1:0]       op_pair, cap_pair;
   logic             is_mul, cap_neg;

   // shared adder
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   // division step helpers
   logic [DW:0]   div_rem;
   logic          div_q;
   logic [DW-1:0] div_r_next, div_n_next;
   logic          sub_sign;

   // result packing
   logic             fit_n, fit_d;
   logic [WIDTH-1:0] lim;
   logic [WIDTH-1:0] enc_n, enc_d;

   rau_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   rau_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;
   assign is_mul      = (act_ff == ACT_MUL);

   // pair 0: na*db (na*nb for multiply), pair 1: da*nb (da*db), pair 2: da*db
   always_comb begin
      unique case (state_ff)
         ST_MUL0: op_pair = 2'd0;
         ST_MUL1: op_pair = 2'd1;
         default: op_pair = 2'd2;
      endcase
      unique case (state_ff)
         ST_MUL1: cap_pair = 2'd0;
         ST_MUL2: cap_pair = 2'd1;
         default: cap_pair = 2'd2;
      endcase
      mul_a = (op_pair == 2'd0) ? mna_ff : mda_ff;
      if (op_pair == 2'd2) begin
         mul_b = mdb_ff;
      end else begin
         mul_b = ((op_pair == 2'd0) ^ is_mul) ? mdb_ff : mnb_ff;
      end
      if (cap_pair == 2'd2) begin
         cap_neg = sda_ff ^ sdb_ff;
      end else begin
         cap_neg = ((cap_pair == 2'd0) ? sna_ff : sda_ff)
                   ^ (((cap_pair == 2'd0) ^ is_mul) ? sdb_ff : snb_ff);
      end
      cap_neg = cap_neg & (prod != '0);
   end

   // sign of the second term after subtract flips it
   assign sub_sign = s1_ff ^ ((act_ff == ACT_SUB) & (p1_ff != '0));

   // one restoring division step, remainder against the gcd
   assign div_rem    = {dr_ff, dn_ff[DW-1]};
   assign div_q      = ~alu_rsp.borrow;
   assign div_r_next = div_q ? alu_rsp.res[DW-1:0] : div_rem[DW-1:0];
   assign div_n_next = {dn_ff[DW-2:0], div_q};

   // result range check and two's complement encoding
   assign lim   = {1'b1, {(WIDTH-1){1'b0}}};
   assign fit_n = (num_m_ff[DW-1:WIDTH] == '0)
                  && (num_s_ff ? (num_m_ff[WIDTH-1:0] <= lim)
                               : (num_m_ff[WIDTH-1:0] < lim));
   assign fit_d = (den_m_ff[DW-1:WIDTH] == '0)
                  && (den_s_ff ? (den_m_ff[WIDTH-1:0] <= lim)
                               : (den_m_ff[WIDTH-1:0] < lim));
   assign enc_n = num_s_ff ? (~num_m_ff[WIDTH-1:0] + 1'b1) : num_m_ff[WIDTH-1:0];
   assign enc_d = den_s_ff ? (~den_m_ff[WIDTH-1:0] + 1'b1) : den_m_ff[WIDTH-1:0];

   // shared adder operand select
   always_comb begin
      alu_req = '0;
      unique case (state_ff)
         ST_ADD: begin
            alu_req.sub = (s0_ff != sub_sign);
            alu_req.x   = {1'b0, p0_ff};
            alu_req.y   = {1'b0, p1_ff};
         end
         ST_ADD_SWAP: begin
            alu_req.sub = 1'b1;
            alu_req.x   = {1'b0, p1_ff};
            alu_req.y   = {1'b0, p0_ff};
         end
         ST_GCD_LOOP: begin
            alu_req.sub = 1'b1;
            alu_req.x   = {1'b0, gb_ff};
            alu_req.y   = {1'b0, ga_ff};
         end
         ST_DIV_NUM, ST_DIV_DEN: begin
            alu_req.sub = 1'b1;
            alu_req.x   = div_rem;
            alu_req.y   = {1'b0, ga_ff};
         end
         default: begin
            alu_req = '0;
         end
      endcase
   end

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      sna_in = sna_ff; sda_in = sda_ff; snb_in = snb_ff; sdb_in = sdb_ff;
      mna_in = mna_ff; mda_in = mda_ff; mnb_in = mnb_ff; mdb_in = mdb_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff;
      s0_in = s0_ff; s1_in = s1_ff; s2_in = s2_ff;
      num_m_in = num_m_ff; num_s_in = num_s_ff;
      den_m_in = den_m_ff; den_s_in = den_s_ff;
      ga_in = ga_ff; gb_in = gb_ff; k_in = k_ff;
      dn_in = dn_ff; dr_in = dr_ff; cnt_in = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in = req_payload.action;
               sna_in = req_payload.num_a[WIDTH-1];
               sda_in = req_payload.den_a[WIDTH-1];
               snb_in = req_payload.num_b[WIDTH-1];
               sdb_in = req_payload.den_b[WIDTH-1];
               mna_in = sna_in ? (~req_payload.num_a + 1'b1) : req_payload.num_a;
               mda_in = sda_in ? (~req_payload.den_a + 1'b1) : req_payload.den_a;
               mnb_in = snb_in ? (~req_payload.num_b + 1'b1) : req_payload.num_b;
               mdb_in = sdb_in ? (~req_payload.den_b + 1'b1) : req_payload.den_b;
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            p0_in    = prod;
            s0_in    = cap_neg;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p1_in    = prod;
            s1_in    = cap_neg;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            p2_in    = prod;
            s2_in    = cap_neg;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_GCD_INIT;
            if (act_ff == ACT_ADD || act_ff == ACT_SUB) begin
               den_m_in = p2_ff;
               den_s_in = s2_ff;
               num_m_in = alu_rsp.res[DW-1:0];
               num_s_in = s0_ff & (alu_rsp.res[DW-1:0] != '0);
               if (alu_rsp.borrow) begin
                  state_in = ST_ADD_SWAP;
               end
            end else begin
               num_m_in = p0_ff;
               num_s_in = s0_ff;
               den_m_in = p1_ff;
               den_s_in = s1_ff;
            end
         end
         ST_ADD_SWAP: begin
            // second term larger: magnitude flips, sign follows that term
            num_m_in = alu_rsp.res[DW-1:0];
            num_s_in = sub_sign;
            state_in = ST_GCD_INIT;
         end
         ST_GCD_INIT: begin
            ga_in = num_m_ff;
            gb_in = den_m_ff;
            k_in  = '0;
            priority if (num_m_ff == '0 && den_m_ff == '0) begin
               state_in = ST_FINISH;
            end else if (num_m_ff == '0) begin
               ga_in    = den_m_ff;
               state_in = ST_DIV_LOAD;
            end else if (den_m_ff == '0) begin
               state_in = ST_DIV_LOAD;
            end else begin
               state_in = ST_GCD_TWO;
            end
         end
         ST_GCD_TWO: begin
            // strip common factors of two
            if (ga_ff[0] | gb_ff[0]) begin
               state_in = ST_GCD_AODD;
            end else begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in  = k_ff + 1'b1;
            end
         end
         ST_GCD_AODD: begin
            if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else begin
               state_in = ST_GCD_LOOP;
            end
         end
         ST_GCD_LOOP: begin
            priority if (gb_ff == '0) begin
               state_in = ST_GCD_SHL;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (alu_rsp.borrow) begin
               // a larger than b: swap, subtract next cycle
               ga_in = gb_ff;
               gb_in = ga_ff;
            end else begin
               gb_in = alu_rsp.res[DW-1:0];
            end
         end
         ST_GCD_SHL: begin
            if (k_ff == '0) begin
               state_in = ST_DIV_LOAD;
            end else begin
               ga_in = ga_ff << 1;
               k_in  = k_ff - 1'b1;
            end
         end
         ST_DIV_LOAD: begin
            dn_in    = num_m_ff;
            dr_in    = '0;
            cnt_in   = '0;
            state_in = ST_DIV_NUM;
         end
         ST_DIV_NUM: begin
            dr_in  = div_r_next;
            dn_in  = div_n_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DW - 1)) begin
               num_m_in = div_n_next;
               dn_in    = den_m_ff;
               dr_in    = '0;
               cnt_in   = '0;
               state_in = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            dr_in  = div_r_next;
            dn_in  = div_n_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DW - 1)) begin
               den_m_in = div_n_next;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_strobe_in  = 1'b1;
            rsp_in.num_out = '0;
            rsp_in.den_out = '0;
            priority if (num_m_ff == '0 && den_m_ff == '0) begin
               rsp_in.status = STAT_ZDEN;
            end else if (!fit_n || !fit_d) begin
               rsp_in.status = STAT_OVF;
            end else begin
               rsp_in.num_out = enc_n;
               rsp_in.den_out = enc_d;
               rsp_in.status  = (den_m_ff == '0) ? STAT_ZDEN : STAT_OK;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff <= act_in;
      sna_ff <= sna_in; sda_ff <= sda_in; snb_ff <= snb_in; sdb_ff <= sdb_in;
      mna_ff <= mna_in; mda_ff <= mda_in; mnb_ff <= mnb_in; mdb_ff <= mdb_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in;
      s0_ff <= s0_in; s1_ff <= s1_in; s2_ff <= s2_in;
      num_m_ff <= num_m_in; num_s_ff <= num_s_in;
      den_m_ff <= den_m_in; den_s_ff <= den_s_in;
      ga_ff <= ga_in; gb_ff <= gb_in; k_ff <= k_in;
      dn_ff <= dn_in; dr_ff <= dr_in; cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

`ifndef ASSERT_OFF
   // a result beat only appears once the sequencer is back in idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // an accepted beat always starts the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start work");

   // overflow results carry zero fields
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == STAT_OVF)
         |-> (rsp_payload.num_out == '0 && rsp_payload.den_out == '0))
      else $error("overflow result not cleared");

   // status never takes the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.status == STAT_OK
                      || rsp_payload.status == STAT_ZDEN
                      || rsp_payload.status == STAT_OVF))
      else $error("bad status code");
`endif

endmodule
